// File: src/rfgt_pkg.sv
// Package for the RTU frame-gap timer: request codes, register indexes, reset values, types.
`default_nettype none

package rfgt_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int THR_W           = 16;
    localparam int BYTE_W          = 8;
    localparam int REQ_W           = 2;
    localparam int CFG_INDEX_W     = 2;

    localparam logic [REQ_W-1:0] REQ_TICK = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BYTE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TX   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_GAP_SHORT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP_EXTRA = 2'd1;

    localparam logic [THR_W-1:0] GAP_SHORT_RESET = 16'd1500;
    localparam logic [THR_W-1:0] GAP_EXTRA_RESET = 16'd2000;

    typedef struct packed {
        logic              byte_valid;
        logic [BYTE_W-1:0] byte_out;
        logic              frame_error;
        logic              gap_short_expired;
        logic              gap_long_expired;
    } result_t;

endpackage

`default_nettype wire

// File: src/rtu_frame_gap_timer.sv
// RTU frame-gap timer: tick counter, 1.5T/3.5T gap compare and two-entry result buffer.
//
// Channel   Direction  Handshake             Payload
// s_        in         s_valid / s_ready     s_req_type, s_rx_byte, s_line_error
// m_        out        m_valid / m_ready     m_byte_valid, m_byte_out, m_frame_error,
//                                            m_gap_short_expired, m_gap_long_expired
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Every beat's result is registered at the edge that accepts it, into the output register
// or, while that holds a result not taken, into the skid register. One beat per cycle is
// sustained while m_ready is high. The result path is an output register plus a skid
// register; s_ready drops only while both hold results that have not been taken. Configuration writes are always ready.
// Reset (aresetn low, synchronous) stops the timer, clears the counter and the buffer,
// and loads the default thresholds.
`default_nettype none

module rtu_frame_gap_timer #(
    parameter int COUNT_WIDTH = rfgt_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [rfgt_pkg::REQ_W-1:0]         s_req_type,
    input  wire logic [rfgt_pkg::BYTE_W-1:0]        s_rx_byte,
    input  wire logic                               s_line_error,

    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_byte_valid,
    output logic [rfgt_pkg::BYTE_W-1:0]             m_byte_out,
    output logic                                    m_frame_error,
    output logic                                    m_gap_short_expired,
    output logic                                    m_gap_long_expired,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [rfgt_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [rfgt_pkg::THR_W-1:0]         cfg_data
);

    // The compare runs at the wider of counter and threshold, so a threshold beyond
    // the counter range never matches.
    localparam int CMP_W = (COUNT_WIDTH > rfgt_pkg::THR_W) ? COUNT_WIDTH : rfgt_pkg::THR_W;

    logic [rfgt_pkg::THR_W-1:0] gap_short_reg;
    logic [rfgt_pkg::THR_W-1:0] gap_extra_reg;

    logic [COUNT_WIDTH-1:0] tick_count_reg, tick_count_next;
    logic                   past_short_reg, past_short_next;
    logic                   running_reg, running_next;

    rfgt_pkg::result_t result_next;
    rfgt_pkg::result_t head_reg;
    rfgt_pkg::result_t skid_reg;
    logic              head_valid_reg;
    logic              skid_valid_reg;

    logic                        push;
    logic                        pop;
    logic [COUNT_WIDTH-1:0]      count_inc;
    logic [rfgt_pkg::THR_W-1:0]  thr;
    logic                        match;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign push      = s_valid && s_ready;
    assign pop       = head_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_short_reg <= rfgt_pkg::GAP_SHORT_RESET;
            gap_extra_reg <= rfgt_pkg::GAP_EXTRA_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rfgt_pkg::CFG_GAP_SHORT: gap_short_reg <= cfg_data;
                rfgt_pkg::CFG_GAP_EXTRA: gap_extra_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign count_inc = tick_count_reg + COUNT_WIDTH'(1);
    assign thr       = past_short_reg ? gap_extra_reg : gap_short_reg;
    assign match     = (CMP_W'(count_inc) == CMP_W'(thr));

    always_comb begin
        tick_count_next = tick_count_reg;
        past_short_next = past_short_reg;
        running_next    = running_reg;
        result_next     = '0;
        unique case (s_req_type)
            rfgt_pkg::REQ_TICK: begin
                if (running_reg) begin
                    if (match) begin
                        tick_count_next = '0;
                        if (!past_short_reg) begin
                            past_short_next               = 1'b1;
                            result_next.gap_short_expired = 1'b1;
                        end else begin
                            past_short_next              = 1'b0;
                            running_next                 = 1'b0;
                            result_next.gap_long_expired = 1'b1;
                        end
                    end else begin
                        tick_count_next = count_inc;
                    end
                end
            end
            rfgt_pkg::REQ_BYTE: begin
                if (s_line_error) begin
                    result_next.frame_error = 1'b1;
                end else begin
                    result_next.byte_valid  = 1'b1;
                    result_next.byte_out    = s_rx_byte;
                    result_next.frame_error = past_short_reg;
                end
                tick_count_next = '0;
                past_short_next = 1'b0;
                running_next    = 1'b1;
            end
            rfgt_pkg::REQ_TX: begin
                past_short_next = 1'b0;
                running_next    = 1'b0;
            end
            rfgt_pkg::REQ_NONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg <= '0;
            past_short_reg <= 1'b0;
            running_reg    <= 1'b0;
        end else if (push) begin
            tick_count_reg <= tick_count_next;
            past_short_reg <= past_short_next;
            running_reg    <= running_next;
        end
    end

    // Result buffer: the skid register fills only when the head is occupied and not taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                if (skid_valid_reg) begin
                    head_valid_reg <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    head_valid_reg <= push;
                end
            end else if (push) begin
                if (head_valid_reg) begin
                    skid_valid_reg <= 1'b1;
                end else begin
                    head_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            if (skid_valid_reg) begin
                head_reg <= skid_reg;
            end else if (push) begin
                head_reg <= result_next;
            end
        end else if (push) begin
            if (head_valid_reg) begin
                skid_reg <= result_next;
            end else begin
                head_reg <= result_next;
            end
        end
    end

    assign m_valid             = head_valid_reg;
    assign m_byte_valid        = head_reg.byte_valid;
    assign m_byte_out          = head_reg.byte_out;
    assign m_frame_error       = head_reg.frame_error;
    assign m_gap_short_expired = head_reg.gap_short_expired;
    assign m_gap_long_expired  = head_reg.gap_long_expired;

endmodule

`default_nettype wire
